### sv/pv2_pkg.sv
// ----------------------------------------------------------------------------
// pv2_pkg
// Types, constants and round functions of the PRINCEv2 block cipher pipeline.
// ----------------------------------------------------------------------------
package pv2_pkg;

  typedef logic [63:0] blk_t;
  typedef logic [3:0]  nib_t;
  typedef logic [3:0]  stage_idx_t;

  typedef enum logic [0:0] {
    REG_KEY0 = 1'b0,
    REG_KEY1 = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    blk_t rk0;
    blk_t rk1;
  } pv2_keys_t;

  localparam int unsigned NUM_STAGES = 11;
  localparam int unsigned NUM_NIBS   = 16;

  localparam blk_t ALPHA = 64'hc0ac29b7c97c50dd;
  localparam blk_t BETA  = 64'h3f84d5b5b5470917;

  localparam blk_t RCON [11] = '{
    64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
    64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c,
    64'h7ef84f78fd955cb1, 64'h85840851f1ac43aa, 64'hc882d32f25323c54,
    64'h64a51195e0e3610d, 64'hd3b5a399ca0c2399
  };

  localparam nib_t SBOX_FWD [16] = '{
    4'hb, 4'hf, 4'h3, 4'h2, 4'ha, 4'hc, 4'h9, 4'h1,
    4'h6, 4'h7, 4'h8, 4'h0, 4'he, 4'h5, 4'hd, 4'h4
  };

  localparam nib_t SBOX_INV [16] = '{
    4'hb, 4'h7, 4'h3, 4'h2, 4'hf, 4'hd, 4'h8, 4'h9,
    4'ha, 4'h6, 4'h4, 4'h0, 4'h5, 4'he, 4'hc, 4'h1
  };

  localparam nib_t PERM_FWD [16] = '{
    4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
  };

  localparam nib_t PERM_INV [16] = '{
    4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
    4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3
  };

  localparam nib_t DIAG_MASK [4] = '{4'd7, 4'd11, 4'd13, 4'd14};

  function automatic blk_t sub_fwd(input blk_t x);
    blk_t r;
    for (int i = 0; i < NUM_NIBS; i++) begin
      r[63-4*i -: 4] = SBOX_FWD[x[63-4*i -: 4]];
    end
    return r;
  endfunction

  function automatic blk_t sub_inv(input blk_t x);
    blk_t r;
    for (int i = 0; i < NUM_NIBS; i++) begin
      r[63-4*i -: 4] = SBOX_INV[x[63-4*i -: 4]];
    end
    return r;
  endfunction

  function automatic blk_t perm_fwd(input blk_t x);
    blk_t r;
    for (int i = 0; i < NUM_NIBS; i++) begin
      r[63-4*i -: 4] = x[63-4*int'(PERM_FWD[i]) -: 4];
    end
    return r;
  endfunction

  function automatic blk_t perm_inv(input blk_t x);
    blk_t r;
    for (int i = 0; i < NUM_NIBS; i++) begin
      r[63-4*i -: 4] = x[63-4*int'(PERM_INV[i]) -: 4];
    end
    return r;
  endfunction

  // nibble 0 of the chunk sits in bits 15:12
  function automatic logic [15:0] mix_chunk(input logic [15:0] c, input logic [1:0] sel);
    logic [15:0] r;
    nib_t        acc;
    logic [1:0]  m;
    for (int row = 0; row < 4; row++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        m   = 2'(row + k) + sel;
        acc = acc ^ (DIAG_MASK[m] & c[15-4*k -: 4]);
      end
      r[15-4*row -: 4] = acc;
    end
    return r;
  endfunction

  function automatic blk_t mix_layer(input blk_t x);
    return {mix_chunk(x[63:48], 2'd0), mix_chunk(x[47:32], 2'd1),
            mix_chunk(x[31:16], 2'd1), mix_chunk(x[15:0], 2'd0)};
  endfunction

  function automatic pv2_keys_t key_sched(input logic dec, input blk_t k0, input blk_t k1,
                                          input logic post);
    pv2_keys_t r;
    r.rk0 = dec ? (k1 ^ BETA) : k0;
    r.rk1 = dec ? (k0 ^ ALPHA) : k1;
    if (dec && post) begin
      r.rk0 = r.rk0 ^ ALPHA ^ BETA;
      r.rk1 = r.rk1 ^ ALPHA ^ BETA;
    end
    return r;
  endfunction

  // stages 0..4: whitening and forward rounds, 5: middle, 6..10: inverse rounds and whitening
  function automatic blk_t stage_fn(input stage_idx_t s, input logic dec, input blk_t x,
                                    input blk_t k0, input blk_t k1);
    pv2_keys_t  pre;
    pv2_keys_t  post;
    blk_t       b;
    stage_idx_t rnd;
    pre  = key_sched(dec, k0, k1, 1'b0);
    post = key_sched(dec, k0, k1, 1'b1);
    rnd  = s + 4'd1;
    b    = x;
    if (s < 4'd5) begin
      if (s == 4'd0) begin
        b = b ^ pre.rk0;
      end
      b = perm_fwd(mix_layer(sub_fwd(b)));
      b = b ^ RCON[rnd] ^ (rnd[0] ? pre.rk1 : pre.rk0);
    end else if (s == 4'd5) begin
      b = sub_fwd(b) ^ pre.rk0;
      b = mix_layer(b) ^ post.rk1 ^ BETA;
      b = sub_inv(b);
    end else begin
      b = b ^ (s[0] ? post.rk1 : post.rk0) ^ RCON[s];
      b = sub_inv(mix_layer(perm_inv(b)));
      if (s == 4'(NUM_STAGES - 1)) begin
        b = b ^ post.rk1 ^ BETA;
      end
    end
    return b;
  endfunction

endpackage

### sv/pv2_in_if.sv
// ----------------------------------------------------------------------------
// pv2_in_if
// Request channel into the cipher: op bit and one 64-bit block.
// ----------------------------------------------------------------------------
interface pv2_in_if;
  import pv2_pkg::*;

  logic valid;
  logic ready;
  logic op;
  blk_t data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink   (input valid, input op, input data_in, output ready);
endinterface

### sv/pv2_out_if.sv
// ----------------------------------------------------------------------------
// pv2_out_if
// Result channel out of the cipher: one 64-bit block.
// ----------------------------------------------------------------------------
interface pv2_out_if;
  import pv2_pkg::*;

  logic valid;
  logic ready;
  blk_t data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

### sv/prince_v2_block_cipher.sv
// ----------------------------------------------------------------------------
// prince_v2_block_cipher
// PRINCEv2 encrypt/decrypt in an eleven-stage pipeline, one round per stage.
//
//   port      dir   payload                     handshake
//   in_ch     in    op, data_in[63:0]           valid/ready
//   out_ch    out   data_out[63:0]              valid/ready
//   cfg_*     in    cfg_index, cfg_wdata[63:0]  cfg_we, no back-pressure
//
// One request per cycle while out_ch is not stalled; one register stage per round
// (whitening joins the first and last rounds, the middle layer has its own).
// Each stage advances when empty or when the stage after it advances, so
// bubbles close up during an output stall and nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits and both key registers.
// ----------------------------------------------------------------------------
module prince_v2_block_cipher (
  input  logic               clk,
  input  logic               rst_n,
  pv2_in_if.sink             in_ch,
  pv2_out_if.source          out_ch,
  input  logic               cfg_we,
  input  pv2_pkg::cfg_idx_t  cfg_index,
  input  pv2_pkg::blk_t      cfg_wdata
);
  import pv2_pkg::*;

  blk_t                  key0_r;
  blk_t                  key1_r;
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] op_r;
  blk_t                  data_r [NUM_STAGES];
  logic [NUM_STAGES:0]   stg_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0: key0_r <= cfg_wdata;
        REG_KEY1: key1_r <= cfg_wdata;
        default:  key0_r <= key0_r;
      endcase
    end
  end

  assign stg_rdy[NUM_STAGES] = out_ch.ready;
  assign in_ch.ready         = stg_rdy[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    logic vld_prev;
    logic op_prev;
    blk_t data_prev;

    if (g == 0) begin : g_first
      assign vld_prev  = in_ch.valid;
      assign op_prev   = in_ch.op;
      assign data_prev = in_ch.data_in;
    end else begin : g_next
      assign vld_prev  = vld_r[g-1];
      assign op_prev   = op_r[g-1];
      assign data_prev = data_r[g-1];
    end

    assign stg_rdy[g] = !vld_r[g] || stg_rdy[g+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (stg_rdy[g]) begin
        vld_r[g] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (stg_rdy[g] && vld_prev) begin
        op_r[g]   <= op_prev;
        data_r[g] <= stage_fn(4'(g), op_prev, data_prev, key0_r, key1_r);
      end
    end
  end

  assign out_ch.valid    = vld_r[NUM_STAGES-1];
  assign out_ch.data_out = data_r[NUM_STAGES-1];

endmodule
